// ===== rtl/aarm_pkg.sv =====
package aarm_pkg;

  // Widths of the CORDIC datapath (Q30 sine/cosine with headroom)
  localparam int XW = 33;
  localparam int ZW = 33;
  localparam int AW = 16;

  // CORDIC gain 0.60725293500888 in Q30
  localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [AW-1:0] ax;
    logic signed [AW-1:0] ay;
    logic signed [AW-1:0] az;
    logic                 flip;
  } cdc_t;

  // Arctangent of 2^-i, full turn = 2^32
  function automatic logic [31:0] atan_val(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/aarm_cordic_cell.sv =====
module aarm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  aarm_pkg::cdc_t      in_d,
  output logic                out_valid,
  output aarm_pkg::cdc_t      out_d
);

  localparam logic signed [aarm_pkg::ZW-1:0] ANG =
    $signed({1'b0, aarm_pkg::atan_val(STAGE)});

  logic                      valid_r;
  aarm_pkg::cdc_t            d_r;
  aarm_pkg::cdc_t            d_nxt;
  logic signed [aarm_pkg::XW-1:0] dx;
  logic signed [aarm_pkg::XW-1:0] dy;

  always_comb begin
    dx    = in_d.y >>> STAGE;
    dy    = in_d.x >>> STAGE;
    d_nxt = in_d;
    // rotate toward zero residual angle
    if (!in_d.z[aarm_pkg::ZW-1]) begin
      d_nxt.x = in_d.x - dx;
      d_nxt.y = in_d.y + dy;
      d_nxt.z = in_d.z - ANG;
    end else begin
      d_nxt.x = in_d.x + dx;
      d_nxt.y = in_d.y - dy;
      d_nxt.z = in_d.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

// ===== rtl/aarm_row_unit.sv =====
module aarm_row_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tl_valid,
  input  aarm_pkg::cdc_t      tl_d,
  output logic                tl_take,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_row_index,
  output logic signed [15:0]  out_col_x,
  output logic signed [15:0]  out_col_y,
  output logic signed [15:0]  out_col_z,
  output logic signed [15:0]  out_col_w,
  output logic                out_last_row
);

  localparam int XW = aarm_pkg::XW;
  localparam int AW = aarm_pkg::AW;
  localparam int OW = XW + 1;
  localparam int QW = 2 * AW;
  localparam int LW = AW + XW + 1;
  localparam int PW = QW + OW;
  localparam int SW = PW + 2;

  localparam logic signed [OW-1:0] ONE_Q30 = OW'(64'sd1 <<< 30);
  localparam logic signed [SW-1:0] RND_F   = SW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] RND_30  = SW'(64'sd1 <<< 29);
  localparam logic signed [SW-1:0] SAT_HI  = SW'(64'sd32767);
  localparam logic signed [SW-1:0] SAT_LO  = SW'(-64'sd32768);
  localparam logic signed [15:0]   ONE_W   =
    (FRAC_BITS >= 15) ? 16'sh7fff : 16'(64'sd1 <<< FRAC_BITS);

  logic adv;

  // row sequencer holding one transaction
  logic                 em_v_r, em_v_nxt;
  logic [1:0]           em_row_r, em_row_nxt;
  logic signed [XW-1:0] em_c_r, em_s_r;
  logic signed [OW-1:0] em_omc_r;
  logic signed [AW-1:0] em_ax_r, em_ay_r, em_az_r;
  logic signed [XW-1:0] ld_c, ld_s;

  // stage 1: axis products and linear terms
  logic                 s1_v_r;
  logic [1:0]           s1_row_r;
  logic signed [QW-1:0] s1_p_r [3];
  logic signed [LW-1:0] s1_l_r [3];
  logic [2:0]           s1_dg_r;
  logic signed [XW-1:0] s1_c_r;
  logic signed [OW-1:0] s1_omc_r;

  // stage 2: products scaled by one minus cosine
  logic                 s2_v_r;
  logic [1:0]           s2_row_r;
  logic signed [PW-1:0] s2_m_r [3];
  logic signed [LW-1:0] s2_l_r [3];
  logic [2:0]           s2_dg_r;
  logic signed [XW-1:0] s2_c_r;

  // stage 3: entry sums in Q(F+30)
  logic                 s3_v_r;
  logic [1:0]           s3_row_r;
  logic signed [SW-1:0] s3_sum_r [3];

  logic                 out_valid_r;
  logic [1:0]           out_row_r;
  logic signed [15:0]   out_col_r [3];
  logic signed [15:0]   out_w_r;

  logic signed [AW-1:0] arow;
  logic signed [QW-1:0] p_c [3];
  logic signed [LW-1:0] sx, sy, sz;
  logic signed [LW-1:0] l_c [3];
  logic signed [SW-1:0] sum_c [3];
  logic signed [15:0]   col_c [3];

  function automatic logic signed [15:0] sat_round(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    logic signed [15:0]   o;
    r = (v + RND_30) >>> 30;
    if (r > SAT_HI) begin
      o = 16'sh7fff;
    end else if (r < SAT_LO) begin
      o = -16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  assign adv     = !out_valid_r || out_ready;
  assign tl_take = adv && (!em_v_r || em_row_r == 2'd3);

  assign ld_c = tl_d.flip ? -tl_d.x : tl_d.x;
  assign ld_s = tl_d.flip ? -tl_d.y : tl_d.y;

  always_comb begin
    em_v_nxt   = em_v_r;
    em_row_nxt = em_row_r;
    if (tl_take) begin
      em_v_nxt   = tl_valid;
      em_row_nxt = 2'd0;
    end else if (adv && em_v_r) begin
      em_row_nxt = em_row_r + 2'd1;
    end
  end

  always_comb begin
    unique case (em_row_r)
      2'd0: arow = em_ax_r;
      2'd1: arow = em_ay_r;
      2'd2: arow = em_az_r;
      2'd3: arow = '0;
    endcase
    p_c[0] = QW'(arow) * QW'(em_ax_r);
    p_c[1] = QW'(arow) * QW'(em_ay_r);
    p_c[2] = QW'(arow) * QW'(em_az_r);
    sx = LW'(em_ax_r) * LW'(em_s_r);
    sy = LW'(em_ay_r) * LW'(em_s_r);
    sz = LW'(em_az_r) * LW'(em_s_r);
    unique case (em_row_r)
      2'd0: begin
        l_c[0] = '0;  l_c[1] = -sz; l_c[2] = sy;
      end
      2'd1: begin
        l_c[0] = sz;  l_c[1] = '0;  l_c[2] = -sx;
      end
      2'd2: begin
        l_c[0] = -sy; l_c[1] = sx;  l_c[2] = '0;
      end
      2'd3: begin
        l_c[0] = '0;  l_c[1] = '0;  l_c[2] = '0;
      end
    endcase
  end

  always_comb begin
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] lx;
    logic signed [SW-1:0] dg;
    for (int j = 0; j < 3; j++) begin
      t  = SW'(s2_m_r[j]);
      t  = (t + RND_F) >>> FRAC_BITS;
      lx = SW'(s2_l_r[j]);
      dg = SW'(s2_c_r);
      dg = s2_dg_r[j] ? (dg <<< FRAC_BITS) : '0;
      sum_c[j] = t + lx + dg;
      col_c[j] = sat_round(s3_sum_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r      <= 1'b0;
      em_row_r    <= 2'd0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      em_v_r   <= em_v_nxt;
      em_row_r <= em_row_nxt;
      if (adv) begin
        s1_v_r      <= em_v_r;
        s2_v_r      <= s1_v_r;
        s3_v_r      <= s2_v_r;
        out_valid_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tl_take && tl_valid) begin
      em_c_r   <= ld_c;
      em_s_r   <= ld_s;
      em_omc_r <= ONE_Q30 - OW'(ld_c);
      em_ax_r  <= tl_d.ax;
      em_ay_r  <= tl_d.ay;
      em_az_r  <= tl_d.az;
    end
    if (adv) begin
      s1_row_r <= em_row_r;
      s1_c_r   <= em_c_r;
      s1_omc_r <= em_omc_r;
      s2_row_r <= s1_row_r;
      s2_c_r   <= s1_c_r;
      s2_dg_r  <= s1_dg_r;
      s3_row_r <= s2_row_r;
      out_row_r <= s3_row_r;
      for (int j = 0; j < 3; j++) begin
        s1_p_r[j]   <= p_c[j];
        s1_l_r[j]   <= l_c[j];
        s1_dg_r[j]  <= (em_row_r == 2'(j));
        s2_m_r[j]   <= PW'(s1_p_r[j]) * PW'(s1_omc_r);
        s2_l_r[j]   <= s1_l_r[j];
        s3_sum_r[j] <= sum_c[j];
        // last row is the constant 0, 0, 0, 1
        out_col_r[j] <= (s3_row_r == 2'd3) ? 16'sd0 : col_c[j];
      end
      out_w_r <= (s3_row_r == 2'd3) ? ONE_W : 16'sd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col_x     = out_col_r[0];
  assign out_col_y     = out_col_r[1];
  assign out_col_z     = out_col_r[2];
  assign out_col_w     = out_w_r;
  assign out_last_row  = (out_row_r == 2'd3);

`ifndef SYNTHESIS
  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_row_index != 2'd3) |=>
      (out_valid && out_row_index == $past(out_row_index) + 2'd1))
    else $error("row sequence broken within a transaction");

  a_row_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (em_row_r != 2'd0) |-> em_v_r)
    else $error("row counter advanced without a held transaction");

  a_last_row_const: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_row) |->
      (out_col_x == 16'sd0 && out_col_y == 16'sd0 && out_col_z == 16'sd0 &&
       out_col_w == ONE_W))
    else $error("last row is not 0, 0, 0, 1");

  a_col_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_row) |-> (out_col_w == 16'sd0))
    else $error("fourth column nonzero on a rotation row");
`endif

endmodule

// ===== rtl/axis_angle_rotation_matrix_top.sv =====
// Axis-angle rotation matrix builder.
// Input channel (in_valid/in_ready): one transaction carries a 16-bit binary
// angle (65536 is one full turn) and an axis x, y, z in signed Q2.14.
// Output channel (out_valid/out_ready): four transactions per input, rows 0
// to 3 of the 4x4 Rodrigues matrix in Q2.14, entries saturated. Row 3 is
// 0, 0, 0, 1 and carries out_last_row.
// Path: an accepted input passes the CORDIC cells, the row sequencer, stages
// 1 to 3 and the output register, and the other rows follow it.
// Throughput: one row per cycle unless out_ready stalls; the row sequencer
// shares one set of multipliers over the three rows and takes inputs at row 3.
// Sine and cosine come from a chain of CORDIC_STAGES cells, one rotation step
// per cell; up to CORDIC_STAGES inputs queue in the chain while rows drain.
// Reset (rst_n, synchronous) empties the chain and the row pipeline.
// When out_ready is low and a row waits at the output, the row pipeline holds;
// the CORDIC chain keeps filling until its last cell waits, then in_ready drops.
module axis_angle_rotation_matrix_top #(
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row_index,
  output logic signed [15:0] out_col_x,
  output logic signed [15:0] out_col_y,
  output logic signed [15:0] out_col_z,
  output logic signed [15:0] out_col_w,
  output logic               out_last_row
);

  logic                 flip;
  logic [31:0]          w;
  aarm_pkg::cdc_t       stg_d [CORDIC_STAGES+1];
  logic                 stg_v [CORDIC_STAGES+1];
  logic                 cordic_adv;
  logic                 tl_take;

  // fold the second and third quadrants by a half turn
  assign flip = (in_angle[15:14] == 2'd1) || (in_angle[15:14] == 2'd2);
  assign w    = {in_angle[15] ^ flip, in_angle[14:0], 16'h0000};

  assign stg_d[0] = '{
    x:    aarm_pkg::GAIN_Q30,
    y:    '0,
    z:    {w[31], w},
    ax:   in_axis_x,
    ay:   in_axis_y,
    az:   in_axis_z,
    flip: flip
  };
  assign stg_v[0] = in_valid;

  assign cordic_adv = !stg_v[CORDIC_STAGES] || tl_take;
  assign in_ready   = cordic_adv;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    aarm_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (cordic_adv),
      .in_valid  (stg_v[g]),
      .in_d      (stg_d[g]),
      .out_valid (stg_v[g+1]),
      .out_d     (stg_d[g+1])
    );
  end

  aarm_row_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_rows (
    .clk           (clk),
    .rst_n         (rst_n),
    .tl_valid      (stg_v[CORDIC_STAGES]),
    .tl_d          (stg_d[CORDIC_STAGES]),
    .tl_take       (tl_take),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_col_x     (out_col_x),
    .out_col_y     (out_col_y),
    .out_col_z     (out_col_z),
    .out_col_w     (out_col_w),
    .out_last_row  (out_last_row)
  );

endmodule

// ===== tb/rotation_matrix_checker.sv =====
module rotation_matrix_checker #(
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_row_index,
  input  logic signed [15:0] out_col_x,
  input  logic signed [15:0] out_col_y,
  input  logic signed [15:0] out_col_z,
  input  logic signed [15:0] out_col_w,
  input  logic               out_last_row,
  output int                 mismatches,
  output int                 rows_pending,
  output int                 rows_checked
);

  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam int     MAX_PRINTS  = 40;

  localparam logic [31:0] ATAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    logic [1:0]         row;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic signed [15:0] cw;
    logic               last;
  } matrix_row_t;

  matrix_row_t expected_rows[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string tag, input int want, input int got);
    if (want != got)
      report_mismatch($sformatf("row #%0d %s expected %0d got %0d",
                                rows_checked, tag, want, got));
  endtask

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Cosine and sine in Q30; second and third quadrants fold by a half turn.
  function automatic void cordic_sincos(input logic [15:0] ang,
                                        output longint c, output longint s);
    logic        flip;
    logic [31:0] w;
    longint      x, y, z, dx, dy;
    flip = (ang[15:14] == 2'd1) || (ang[15:14] == 2'd2);
    w = {ang, 16'h0000};
    if (flip) w = w - 32'h8000_0000;
    z = {{32{w[31]}}, w};
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'({32'd0, ATAN_STEP[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'({32'd0, ATAN_STEP[i]});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [15:0] mat_entry(input longint prod, input longint omc,
                                                   input longint lin, input longint diag);
    longint t, sum;
    t = (prod * omc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    sum = t + lin + diag;
    return clip16((sum + (longint'(1) << 29)) >>> 30);
  endfunction

  function automatic void predict_matrix(input logic [15:0] ang, input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic signed [15:0] az);
    longint c, s, omc, cd, x, y, z;
    x = longint'(ax);
    y = longint'(ay);
    z = longint'(az);
    cordic_sincos(ang, c, s);
    omc = (longint'(1) << 30) - c;
    cd = c * (longint'(1) << FRAC_BITS);
    expected_rows.push_back('{2'd0, mat_entry(x * x, omc, 0, cd),
                              mat_entry(y * x, omc, -(z * s), 0),
                              mat_entry(z * x, omc, y * s, 0), 16'sd0, 1'b0});
    expected_rows.push_back('{2'd1, mat_entry(x * y, omc, z * s, 0),
                              mat_entry(y * y, omc, 0, cd),
                              mat_entry(z * y, omc, -(x * s), 0), 16'sd0, 1'b0});
    expected_rows.push_back('{2'd2, mat_entry(x * z, omc, -(y * s), 0),
                              mat_entry(y * z, omc, x * s, 0),
                              mat_entry(z * z, omc, 0, cd), 16'sd0, 1'b0});
    expected_rows.push_back('{2'd3, 16'sd0, 16'sd0, 16'sd0,
                              clip16(longint'(1) << FRAC_BITS), 1'b1});
  endfunction

  always @(posedge clk) begin
    matrix_row_t want;
    if (!rst_n) begin
      expected_rows.delete();
      mismatches = 0;
      rows_checked = 0;
      rows_pending <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_matrix(in_angle, in_axis_x, in_axis_y, in_axis_z);
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("row %0d arrived with no transaction pending",
                                    out_row_index));
        end else begin
          want = expected_rows.pop_front();
          check_field("row_index", want.row, out_row_index);
          check_field("col_x", want.cx, out_col_x);
          check_field("col_y", want.cy, out_col_y);
          check_field("col_z", want.cz, out_col_z);
          check_field("col_w", want.cw, out_col_w);
          check_field("last_row", want.last, out_last_row);
          rows_checked++;
        end
      end
      rows_pending <= expected_rows.size();
    end
  end

endmodule

// ===== tb/tb_axis_angle_rotation_matrix_top.sv =====
module tb_axis_angle_rotation_matrix_top;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int RANDOM_ITEMS  = 220;
  localparam int DRAIN_CYCLES  = CORDIC_STAGES + 24;
  localparam int LIMIT_CYCLES  = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_angle = '0;
  logic signed [15:0] in_axis_x = '0;
  logic signed [15:0] in_axis_y = '0;
  logic signed [15:0] in_axis_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_row_index;
  logic signed [15:0] out_col_x;
  logic signed [15:0] out_col_y;
  logic signed [15:0] out_col_z;
  logic signed [15:0] out_col_w;
  logic               out_last_row;

  int mismatches;
  int rows_pending;
  int rows_checked;
  int items_sent = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  axis_angle_rotation_matrix_top #(
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_angle      (in_angle),
    .in_axis_x     (in_axis_x),
    .in_axis_y     (in_axis_y),
    .in_axis_z     (in_axis_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_col_x     (out_col_x),
    .out_col_y     (out_col_y),
    .out_col_z     (out_col_z),
    .out_col_w     (out_col_w),
    .out_last_row  (out_last_row)
  );

  rotation_matrix_checker #(
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_angle      (in_angle),
    .in_axis_x     (in_axis_x),
    .in_axis_y     (in_axis_y),
    .in_axis_z     (in_axis_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_col_x     (out_col_x),
    .out_col_y     (out_col_y),
    .out_col_z     (out_col_z),
    .out_col_w     (out_col_w),
    .out_last_row  (out_last_row),
    .mismatches    (mismatches),
    .rows_pending  (rows_pending),
    .rows_checked  (rows_checked)
  );

  // Stall the row channel now and then, never during the quiet stretch.
  always @(posedge clk)
    out_ready <= quiet || ($urandom_range(99) >= 9);

  task automatic send_rotation(input logic [15:0] ang, input logic signed [15:0] ax,
                               input logic signed [15:0] ay, input logic signed [15:0] az);
    int gap;
    if (!quiet && $urandom_range(99) < 9) begin
      gap = $urandom_range(5, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_angle  <= ang;
    in_axis_x <= ax;
    in_axis_y <= ay;
    in_axis_z <= az;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic signed [15:0] pick_axis(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(32768)) - 16384);
      2: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      default: begin
        if ($urandom_range(3) == 0) return 16'sd0;
        return 16'(int'($urandom_range(2048)) - 1024);
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] edge_pt;
    if ($urandom_range(3) != 0) return 16'($urandom);
    // Land near a quadrant boundary.
    edge_pt = {2'($urandom_range(3)), 14'd0};
    return edge_pt + 16'($urandom_range(4)) - 16'd2;
  endfunction

  initial begin
    int mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, quadrant edges, folded quadrants, saturating and zero axes.
    send_rotation(16'd0,     16'sd16384, 16'sd0,     16'sd0);
    send_rotation(16'd16384, 16'sd0,     16'sd0,     16'sd16384);
    send_rotation(16'd32768, 16'sd0,     16'sd16384, 16'sd0);
    send_rotation(16'd49152, 16'sd16384, 16'sd0,     16'sd0);
    send_rotation(16'd16383, 16'sd0,     16'sd0,     16'sd16384);
    send_rotation(16'd16385, 16'sd0,     16'sd0,     -16'sd16384);
    send_rotation(16'd32767, 16'sd9459,  16'sd9459,  16'sd9459);
    send_rotation(16'd49151, -16'sd9459, 16'sd9459,  -16'sd9459);
    send_rotation(16'd49153, 16'sd11585, 16'sd0,     16'sd11585);
    send_rotation(16'd65535, 16'sd0,     16'sd16384, 16'sd0);
    send_rotation(16'd8192,  16'sd32767, 16'sd32767, 16'sd32767);
    send_rotation(16'd40000, -16'sd32768, -16'sd32768, -16'sd32768);
    send_rotation(16'd24576, -16'sd32768, 16'sd32767, 16'sd0);
    send_rotation(16'd12345, 16'sd0,     16'sd0,     16'sd0);
    send_rotation(16'd65535, 16'sd32767, -16'sd32768, 16'sd32767);
    send_rotation(16'd32768, -16'sd32768, 16'sd0,    16'sd32767);
    send_rotation(16'd1,     16'sd16384, 16'sd16384, 16'sd16384);
    send_rotation(16'hAAAA,  16'sh5555,  16'shAAAA,  16'sh5555);
    send_rotation(16'h5555,  16'shAAAA,  16'sh5555,  16'shAAAA);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 60) begin
        // Hold off until every row of the earlier transactions has drained.
        in_valid <= 1'b0;
        do @(posedge clk); while (rows_pending != 0);
      end
      quiet = (k >= 100) && (k < 150);
      mode = $urandom_range(3);
      send_rotation(pick_angle(), pick_axis(mode), pick_axis(mode), pick_axis(mode));
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d rotations (quadrant edges, saturating and zero axes, random)",
             items_sent);
    $display("Checked %0d matrix rows, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Timed out with %0d rows outstanding", rows_pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule
